// ----- design/pstrk_pkg.sv -----
// Shared types, constants and the axis clamp for the PS/2 mouse packet tracker.
package pstrk_pkg;

	localparam int COORD_W = 13;
	localparam int DELTA_W = 16;
	localparam int BTN_W = 3;
	localparam int SUM_W = ((COORD_W + 1 > DELTA_W) ? COORD_W + 1 : DELTA_W) + 1;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [COORD_W-1:0] WIDTH_RST = COORD_W'(1024);
	localparam logic [COORD_W-1:0] HEIGHT_RST = COORD_W'(768);

	// header byte bits
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;
	localparam int HDR_XOVF_BIT = 6;
	localparam int HDR_YOVF_BIT = 7;
	localparam int BTN_LEFT_BIT = 0;
	localparam int BTN_RIGHT_BIT = 1;

	typedef enum logic [1:0] {
		FUNC_AUX_BYTE = 2'd0,
		FUNC_INJECT   = 2'd1,
		FUNC_INIT     = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_XMOVE  = 3'b010,
		PH_YMOVE  = 3'b100
	} phase_t;

	// One command for the back end: a cursor update or a recenter.
	typedef struct packed {
		logic                      is_init;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [BTN_W-1:0]          buttons;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [COORD_W-1:0]   data;
	} cfg_wr_t;

	function automatic logic [COORD_W-1:0] clamp_axis(
		input logic [COORD_W-1:0] cur,
		input logic signed [DELTA_W-1:0] d,
		input logic [COORD_W-1:0] limit
	);
		logic signed [SUM_W-1:0] p;
		logic signed [SUM_W-1:0] lim;
		logic [COORD_W-1:0] res;
		p = $signed({{(SUM_W - COORD_W){1'b0}}, cur})
			+ $signed({{(SUM_W - DELTA_W){d[DELTA_W-1]}}, d});
		lim = $signed({{(SUM_W - COORD_W){1'b0}}, limit});
		if (limit == '0) begin
			res = '0;
		end else if (p < 0) begin
			res = '0;
		end else if (p >= lim) begin
			res = limit - COORD_W'(1);
		end else begin
			res = p[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- design/pstrk_front.sv -----
// Front end: accepts items, assembles 3-byte packets and issues update and recenter commands.
module pstrk_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [1:0]                          func,
	input  logic [7:0]                          rx_byte,
	input  logic signed [pstrk_pkg::DELTA_W-1:0] inj_dx,
	input  logic signed [pstrk_pkg::DELTA_W-1:0] inj_dy,
	input  logic [7:0]                          inj_buttons,
	output pstrk_pkg::cmd_req_t                 push
);

	pstrk_pkg::phase_t phase_q;
	logic [7:0] header_q;
	logic [7:0] xmove_q;
	logic signed [pstrk_pkg::DELTA_W-1:0] pkt_dx;
	logic signed [pstrk_pkg::DELTA_W-1:0] pkt_dy;
	logic pkt_ovf;

	always_comb begin
		pkt_dx = {{(pstrk_pkg::DELTA_W - 8){header_q[pstrk_pkg::HDR_XSIGN_BIT]}}, xmove_q};
		// invert y so that down is positive
		pkt_dy = -{{(pstrk_pkg::DELTA_W - 8){header_q[pstrk_pkg::HDR_YSIGN_BIT]}}, rx_byte};
		pkt_ovf = header_q[pstrk_pkg::HDR_XOVF_BIT] | header_q[pstrk_pkg::HDR_YOVF_BIT];
	end

	always_comb begin
		push = '0;
		if (accept) begin
			unique case (func)
				pstrk_pkg::FUNC_AUX_BYTE: begin
					if (phase_q == pstrk_pkg::PH_YMOVE && !pkt_ovf) begin
						push.valid = 1'b1;
						push.cmd.dx = pkt_dx;
						push.cmd.dy = pkt_dy;
						push.cmd.buttons = header_q[pstrk_pkg::BTN_W-1:0];
					end
				end
				pstrk_pkg::FUNC_INJECT: begin
					push.valid = 1'b1;
					push.cmd.dx = inj_dx;
					push.cmd.dy = inj_dy;
					push.cmd.buttons = inj_buttons[pstrk_pkg::BTN_W-1:0];
				end
				pstrk_pkg::FUNC_INIT: begin
					push.valid = 1'b1;
					push.cmd.is_init = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pstrk_pkg::PH_HEADER;
			header_q <= '0;
			xmove_q <= '0;
		end else if (accept) begin
			if (func == pstrk_pkg::FUNC_AUX_BYTE) begin
				unique case (phase_q)
					pstrk_pkg::PH_XMOVE: begin
						xmove_q <= rx_byte;
						phase_q <= pstrk_pkg::PH_YMOVE;
					end
					pstrk_pkg::PH_YMOVE: begin
						phase_q <= pstrk_pkg::PH_HEADER;
					end
					default: begin
						// drop bytes without the sync bit to resync
						if (rx_byte[pstrk_pkg::HDR_SYNC_BIT]) begin
							header_q <= rx_byte;
							phase_q <= pstrk_pkg::PH_XMOVE;
						end
					end
				endcase
			end else if (func == pstrk_pkg::FUNC_INIT) begin
				phase_q <= pstrk_pkg::PH_HEADER;
				header_q <= '0;
				xmove_q <= '0;
			end
		end
	end

endmodule

// ----- design/pstrk_queue.sv -----
// Two-entry command queue between the front and back ends.
module pstrk_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  pstrk_pkg::cmd_req_t push,
	input  logic                pop,
	output logic                full,
	output pstrk_pkg::cmd_req_t head
);

	pstrk_pkg::cmd_t entry_q [pstrk_pkg::Q_DEPTH];
	logic [pstrk_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [pstrk_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [pstrk_pkg::Q_CNT_W-1:0] count_q;

	assign full = (count_q == pstrk_pkg::Q_CNT_W'(pstrk_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == pstrk_pkg::Q_PTR_W'(pstrk_pkg::Q_DEPTH - 1))
					? '0 : wr_ptr_q + pstrk_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == pstrk_pkg::Q_PTR_W'(pstrk_pkg::Q_DEPTH - 1))
					? '0 : rd_ptr_q + pstrk_pkg::Q_PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + pstrk_pkg::Q_CNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - pstrk_pkg::Q_CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pstrk_pkg::Q_CNT_W'(pstrk_pkg::Q_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- design/pstrk_back.sv -----
// Back end: screen registers, cursor and button state, and the result register.
module pstrk_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pstrk_pkg::cfg_wr_t                   cfg,
	input  pstrk_pkg::cmd_req_t                  head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [pstrk_pkg::COORD_W-1:0]         pos_x,
	output logic [pstrk_pkg::COORD_W-1:0]         pos_y,
	output logic signed [pstrk_pkg::DELTA_W-1:0]  delta_x,
	output logic signed [pstrk_pkg::DELTA_W-1:0]  delta_y,
	output logic [pstrk_pkg::BTN_W-1:0]           button_bits,
	output logic                                 left_pressed,
	output logic                                 left_released,
	output logic                                 right_pressed
);

	logic [pstrk_pkg::COORD_W-1:0] width_q;
	logic [pstrk_pkg::COORD_W-1:0] height_q;
	logic [pstrk_pkg::COORD_W-1:0] cursor_x_q;
	logic [pstrk_pkg::COORD_W-1:0] cursor_y_q;
	logic [pstrk_pkg::BTN_W-1:0] held_q;
	logic [pstrk_pkg::COORD_W-1:0] next_x;
	logic [pstrk_pkg::COORD_W-1:0] next_y;
	logic [pstrk_pkg::BTN_W-1:0] changed;
	logic out_valid_q;
	logic pop_update;
	logic pop_init;

	assign pop = head.valid && (!out_valid_q || out_ready);
	assign pop_update = pop && !head.cmd.is_init;
	assign pop_init = pop && head.cmd.is_init;
	assign out_valid = out_valid_q;

	always_comb begin
		next_x = pstrk_pkg::clamp_axis(cursor_x_q, head.cmd.dx, width_q);
		next_y = pstrk_pkg::clamp_axis(cursor_y_q, head.cmd.dy, height_q);
		changed = held_q ^ head.cmd.buttons;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pstrk_pkg::WIDTH_RST;
			height_q <= pstrk_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pstrk_pkg::REG_SCREEN_WIDTH: width_q <= cfg.data;
				pstrk_pkg::REG_SCREEN_HEIGHT: height_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= pstrk_pkg::WIDTH_RST >> 1;
			cursor_y_q <= pstrk_pkg::HEIGHT_RST >> 1;
			held_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_init) begin
				cursor_x_q <= width_q >> 1;
				cursor_y_q <= height_q >> 1;
				held_q <= '0;
			end else if (pop_update) begin
				cursor_x_q <= next_x;
				cursor_y_q <= next_y;
				held_q <= head.cmd.buttons;
			end
			// hold the result until taken, then load the next one if any
			if (pop_update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_update) begin
			pos_x <= next_x;
			pos_y <= next_y;
			delta_x <= head.cmd.dx;
			delta_y <= head.cmd.dy;
			button_bits <= head.cmd.buttons;
			left_pressed <= changed[pstrk_pkg::BTN_LEFT_BIT]
				& head.cmd.buttons[pstrk_pkg::BTN_LEFT_BIT];
			left_released <= changed[pstrk_pkg::BTN_LEFT_BIT]
				& ~head.cmd.buttons[pstrk_pkg::BTN_LEFT_BIT];
			right_pressed <= changed[pstrk_pkg::BTN_RIGHT_BIT]
				& head.cmd.buttons[pstrk_pkg::BTN_RIGHT_BIT];
		end
	end

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop_init |=> held_q == '0)
		else $error("init left buttons held");
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop_update))
		else $error("result without update command");

endmodule

// ----- design/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker.
// Takes one item per cycle: aux bytes (func 0) are assembled into 3-byte packets,
// injected deltas (func 1) and recenter requests (func 2) go straight through.
// The front end classifies each item in its accept cycle and pushes a command
// into a two-entry queue; the back end applies one command per cycle to the
// clamped cursor and presents the result the cycle after, in an output register.
// Sustained rate is one item per clock, limited by the single back-end update
// per cycle; a command passes through the queue entry and then the output
// register before out_valid rises. A result held by out_ready low stalls the
// back end, and in_ready drops once the queue holds two commands.
// Only the third byte of a good packet and inject items produce a result.
// Screen registers are written through the cfg channel, which is always ready,
// and should be written only after all results have been taken.
module ps2_mouse_packet_tracker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             func,
	input  logic [7:0]                             rx_byte,
	input  logic signed [pstrk_pkg::DELTA_W-1:0]    inj_dx,
	input  logic signed [pstrk_pkg::DELTA_W-1:0]    inj_dy,
	input  logic [7:0]                             inj_buttons,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pstrk_pkg::COORD_W-1:0]           pos_x,
	output logic [pstrk_pkg::COORD_W-1:0]           pos_y,
	output logic signed [pstrk_pkg::DELTA_W-1:0]    delta_x,
	output logic signed [pstrk_pkg::DELTA_W-1:0]    delta_y,
	output logic [pstrk_pkg::BTN_W-1:0]             button_bits,
	output logic                                   left_pressed,
	output logic                                   left_released,
	output logic                                   right_pressed,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pstrk_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pstrk_pkg::COORD_W-1:0]           cfg_data
);

	pstrk_pkg::cmd_req_t push;
	pstrk_pkg::cmd_req_t head;
	pstrk_pkg::cfg_wr_t cfg;
	logic q_full;
	logic pop;
	logic accept;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.valid = cfg_valid && cfg_ready;
		cfg.index = cfg_index;
		cfg.data = cfg_data;
	end

	pstrk_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.rx_byte     (rx_byte),
		.inj_dx      (inj_dx),
		.inj_dy      (inj_dy),
		.inj_buttons (inj_buttons),
		.push        (push)
	);

	pstrk_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	pstrk_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.button_bits   (button_bits),
		.left_pressed  (left_pressed),
		.left_released (left_released),
		.right_pressed (right_pressed)
	);

endmodule

// ----- sim/tb_ps2_mouse_packet_tracker.sv -----
// Testbench for the PS/2 mouse packet tracker: queued stimulus, cursor prediction, checking.
module tb_ps2_mouse_packet_tracker;
	import pstrk_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD_AT = 20;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 96;

	typedef struct {
		logic [1:0]                func;
		logic [7:0]                rx;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [7:0]                btn;
	} mouse_event_t;

	typedef struct {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
		logic [BTN_W-1:0]   btn;
		logic               lp;
		logic               lr;
		logic               rp;
	} cursor_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic [7:0] rx_byte = '0;
	logic signed [DELTA_W-1:0] inj_dx = '0;
	logic signed [DELTA_W-1:0] inj_dy = '0;
	logic [7:0] inj_buttons = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic [BTN_W-1:0] button_bits;
	logic left_pressed;
	logic left_released;
	logic right_pressed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	ps2_mouse_packet_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.rx_byte(rx_byte),
		.inj_dx(inj_dx),
		.inj_dy(inj_dy),
		.inj_buttons(inj_buttons),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.button_bits(button_bits),
		.left_pressed(left_pressed),
		.left_released(left_released),
		.right_pressed(right_pressed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	mouse_event_t mouse_events[$];
	cursor_report_t cursor_reports[$];
	mouse_event_t on_bus;
	int errors = 0;
	int cycle_count = 0;
	int src_wait = 0;
	int sink_wait = 0;
	int reports_seen = 0;
	bit steady = 1'b0;

	// tracker copy of the block state
	logic [COORD_W-1:0] scr_w = WIDTH_RST;
	logic [COORD_W-1:0] scr_h = HEIGHT_RST;
	phase_t pkt_phase = PH_HEADER;
	logic [7:0] hdr_q = '0;
	logic [7:0] xmove_q = '0;
	logic [COORD_W-1:0] cur_x = COORD_W'(512);
	logic [COORD_W-1:0] cur_y = COORD_W'(384);
	logic [BTN_W-1:0] btn_q = '0;

	function automatic int pick_gap();
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] cur, int d,
		logic [COORD_W-1:0] lim);
		int p;
		p = int'(cur) + d;
		if (lim == '0)
			return '0;
		if (p < 0)
			return '0;
		if (p >= int'(lim))
			return lim - COORD_W'(1);
		return p[COORD_W-1:0];
	endfunction

	function automatic void apply_motion(int dx, int dy, logic [BTN_W-1:0] b);
		cursor_report_t r;
		logic [BTN_W-1:0] changed;
		changed = btn_q ^ b;
		cur_x = clamp_coord(cur_x, dx, scr_w);
		cur_y = clamp_coord(cur_y, dy, scr_h);
		btn_q = b;
		r.pos_x = cur_x;
		r.pos_y = cur_y;
		r.dx = dx[DELTA_W-1:0];
		r.dy = dy[DELTA_W-1:0];
		r.btn = b;
		r.lp = changed[BTN_LEFT_BIT] && b[BTN_LEFT_BIT];
		r.lr = changed[BTN_LEFT_BIT] && !b[BTN_LEFT_BIT];
		r.rp = changed[BTN_RIGHT_BIT] && b[BTN_RIGHT_BIT];
		cursor_reports.push_back(r);
	endfunction

	function automatic void advance_cursor(mouse_event_t ev);
		int dx;
		int dy;
		case (ev.func)
			FUNC_AUX_BYTE: begin
				case (pkt_phase)
					PH_XMOVE: begin
						xmove_q = ev.rx;
						pkt_phase = PH_YMOVE;
					end
					PH_YMOVE: begin
						pkt_phase = PH_HEADER;
						// drop packets with either overflow bit
						if (!hdr_q[HDR_XOVF_BIT] && !hdr_q[HDR_YOVF_BIT]) begin
							dx = int'(xmove_q);
							dy = int'(ev.rx);
							if (hdr_q[HDR_XSIGN_BIT])
								dx -= 256;
							if (hdr_q[HDR_YSIGN_BIT])
								dy -= 256;
							apply_motion(dx, -dy, hdr_q[BTN_W-1:0]);
						end
					end
					default: begin
						pkt_phase = PH_HEADER;
						if (ev.rx[HDR_SYNC_BIT]) begin
							hdr_q = ev.rx;
							pkt_phase = PH_XMOVE;
						end
					end
				endcase
			end
			FUNC_INJECT: apply_motion(int'(ev.dx), int'(ev.dy), ev.btn[BTN_W-1:0]);
			FUNC_INIT: begin
				cur_x = scr_w >> 1;
				cur_y = scr_h >> 1;
				btn_q = '0;
				pkt_phase = PH_HEADER;
				hdr_q = '0;
				xmove_q = '0;
			end
			default: ;
		endcase
	endfunction

	task automatic cmp_field(string nm, logic [DELTA_W-1:0] want, logic [DELTA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, nm, want, got);
			errors++;
		end
	endtask

	task automatic check_report(cursor_report_t e);
		cmp_field("pos_x", e.pos_x, pos_x);
		cmp_field("pos_y", e.pos_y, pos_y);
		cmp_field("delta_x", e.dx, delta_x);
		cmp_field("delta_y", e.dy, delta_y);
		cmp_field("button_bits", e.btn, button_bits);
		cmp_field("left_pressed", e.lp, left_pressed);
		cmp_field("left_released", e.lr, left_released);
		cmp_field("right_pressed", e.rp, right_pressed);
	endtask

	// source side: present queued items, idle at random between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				advance_cursor(on_bus);
				src_wait = pick_gap();
			end
			if (!in_valid || in_ready) begin
				if (src_wait > 0 || mouse_events.size() == 0) begin
					if (src_wait > 0)
						src_wait--;
					in_valid <= 1'b0;
				end else begin
					on_bus = mouse_events.pop_front();
					in_valid <= 1'b1;
					func <= on_bus.func;
					rx_byte <= on_bus.rx;
					inj_dx <= on_bus.dx;
					inj_dy <= on_bus.dy;
					inj_buttons <= on_bus.btn;
				end
			end
		end
	end

	// sink side: check each report, stall at random, hold off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cursor_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none actual x=%0d y=%0d",
						$time, pos_x, pos_y);
					errors++;
				end else begin
					check_report(cursor_reports.pop_front());
				end
				reports_seen++;
				sink_wait = pick_gap();
				if (reports_seen == LONG_HOLD_AT)
					sink_wait = LONG_HOLD_CYCLES;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void queue_event(logic [1:0] f, logic [7:0] b, logic [DELTA_W-1:0] dx,
		logic [DELTA_W-1:0] dy, logic [7:0] bt);
		mouse_event_t ev;
		ev.func = f;
		ev.rx = b;
		ev.dx = dx;
		ev.dy = dy;
		ev.btn = bt;
		mouse_events.push_back(ev);
	endfunction

	function automatic void push_aux(logic [7:0] b);
		queue_event(FUNC_AUX_BYTE, b, DELTA_W'($urandom), DELTA_W'($urandom), 8'($urandom));
	endfunction

	function automatic void push_inject(logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
		logic [7:0] bt);
		queue_event(FUNC_INJECT, 8'($urandom), dx, dy, bt);
	endfunction

	function automatic void push_init();
		queue_event(FUNC_INIT, 8'($urandom), DELTA_W'($urandom), DELTA_W'($urandom),
			8'($urandom));
	endfunction

	function automatic void push_packet(logic [7:0] h, logic [7:0] x, logic [7:0] y);
		push_aux(h);
		push_aux(x);
		push_aux(y);
	endfunction

	function automatic logic [7:0] make_header();
		logic [7:0] h;
		h = 8'($urandom);
		h[HDR_SYNC_BIT] = 1'b1;
		// keep most packets free of overflow
		if ($urandom_range(0, 9) != 0) begin
			h[HDR_XOVF_BIT] = 1'b0;
			h[HDR_YOVF_BIT] = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [DELTA_W-1:0] make_delta();
		int d;
		if ($urandom_range(0, 9) == 0)
			return DELTA_W'($urandom);
		d = $urandom_range(0, 800);
		d -= 400;
		return d[DELTA_W-1:0];
	endfunction

	function automatic void make_traffic(int count);
		int made;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					push_packet(make_header(), 8'($urandom), 8'($urandom));
					made += 3;
				end
				5, 6: begin
					push_inject(make_delta(), make_delta(), 8'($urandom));
					made++;
				end
				7: begin
					// noise byte, often without sync
					push_aux(8'($urandom));
					made++;
				end
				8: begin
					if ($urandom_range(0, 1) == 0)
						push_init();
					else
						queue_event(FUNC_UNUSED, 8'($urandom), DELTA_W'($urandom),
							DELTA_W'($urandom), 8'($urandom));
					made++;
				end
				default: begin
					push_aux(make_header());
					case ($urandom_range(0, 2))
						0: push_init();
						1: begin
							push_aux(8'($urandom));
							push_init();
						end
						default: begin
							// inject lands inside a packet
							push_inject(make_delta(), make_delta(), 8'($urandom));
							push_aux(8'($urandom));
							push_aux(8'($urandom));
						end
					endcase
					made += 3;
				end
			endcase
		end
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_w = val;
		else
			scr_h = val;
		@(negedge clk);
	endtask

	task automatic settle();
		do @(negedge clk); while (mouse_events.size() != 0 || in_valid ||
			cursor_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_inject(16'sh7fff, 16'sh8000, 8'hff);
		push_inject(16'sh8000, 16'sh7fff, 8'h00);
		queue_event(FUNC_UNUSED, 8'hff, 16'hffff, 16'hffff, 8'hff);
		push_aux(8'h07);
		push_packet(8'h1b, 8'h00, 8'h80);
		push_packet(8'h2c, 8'hff, 8'h00);
		push_packet(8'hc9, 8'h12, 8'h34);
		push_packet(8'h88, 8'h01, 8'h01);
		push_aux(8'h09);
		push_aux(8'h10);
		push_init();
		push_packet(8'h08, 8'h01, 8'h01);
		push_aux(8'h0a);
		push_inject(16'sd5, 16'sd5, 8'h01);
		push_aux(8'h05);
		push_aux(8'h05);
		push_inject(16'sd0, 16'sd0, 8'h02);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					w = COORD_W'(1);
					h = COORD_W'(1);
				end
				1: begin
					w = COORD_W'(8191);
					h = COORD_W'(8191);
				end
				2: begin
					// shrink without recentering
					w = COORD_W'(100);
					h = COORD_W'(50);
				end
				3: begin
					w = '0;
					h = '0;
				end
				default: begin
					w = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(1, 8191))
						: COORD_W'($urandom_range(16, 1024));
					h = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(1, 8191))
						: COORD_W'($urandom_range(16, 1024));
				end
			endcase
			write_reg(REG_SCREEN_WIDTH, w);
			write_reg(REG_SCREEN_HEIGHT, h);
			steady = (ph % 3 == 2);
			make_traffic(PHASE_ITEMS);
			settle();
		end

		if (cursor_reports.size() != 0) begin
			$display("%0t: %0d reports expected, none arrived", $time, cursor_reports.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
